// ===== src/wcpb_pkg.sv =====
// ----------------------------------------------------------------------------
// wcpb_pkg: shared constants for the waveform column peak bar block
// request codes, register indexes, reset values and fixed-point constants
// ----------------------------------------------------------------------------
`default_nettype none

package wcpb_pkg;

  // store depth default
  localparam int WCPB_MAX_SAMPLES = 1024;

  // request codes
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_PLOT_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_STRIP_HEIGHT = 2'd1;

  // register reset values
  localparam logic [11:0] PLOT_COLUMNS_RST = 12'd256;
  localparam logic [11:0] STRIP_HEIGHT_RST = 12'd64;

  // smallest strip that draws anything
  localparam logic [11:0] MIN_HEIGHT = 12'd6;

  // 1.0 in q2.14
  localparam logic signed [15:0] Q_ONE = 16'sd16384;
  localparam int Q_FRAC = 14;

endpackage

`default_nettype wire

// ===== src/wcpb_ram.sv =====
// ----------------------------------------------------------------------------
// wcpb_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module wcpb_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/waveform_column_peak_bars.sv =====
// ----------------------------------------------------------------------------
// waveform_column_peak_bars: per-column peak bars for a waveform strip
// stores q2.14 level samples and answers one column query at a time with
// the clamped positive peak of the column's span scaled to a half-height
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    in_req_type, in_sample, in_column
//   out      source     out_valid / out_stall  out_bar_present, out_reach,
//                                              out_store_full
//   cfg      sink       cfg_wr_en              cfg_index, cfg_wdata
//
// clear, append, unknown requests and queries turned away up front go from
// idle straight to the done state, which loads the output register when it
// is free; a query that scans goes through the multiply state, the
// one-bit-a-cycle divider (run twice, DIV_W = 12 + count width, 23 for 1024
// samples), the one-sample-a-cycle scan of the ram read port with its
// registered read data, then the scale and finish states (finish skipped when
// the span peak is not positive). one item is in flight at a time; in_stall is high
// until its result is in the output register. the output register holds under
// out_stall, and a new item may be taken while it waits. rst_n is synchronous:
// it empties the store and loads the register reset values.
`default_nettype none

module waveform_column_peak_bars
  import wcpb_pkg::*;
#(
  parameter int MAX_SAMPLES = WCPB_MAX_SAMPLES
) (
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_req_type,
  input  wire logic signed [15:0] in_sample,
  input  wire logic [11:0]        in_column,

  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_bar_present,
  output logic [10:0]             out_reach,
  output logic                    out_store_full,

  input  wire logic               cfg_wr_en,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [11:0]        cfg_wdata
);

  // count width holds MAX_SAMPLES itself, address width indexes the store
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  // (col + 1) * count stays below 2^12 * 2^CNT_W since col < plot <= 4095
  localparam int DIV_W  = 12 + CNT_W;
  localparam int STEP_W = $clog2(DIV_W);
  // shared multiplier: 15 bit a operand, b operand wide enough for count or scale
  localparam int MB_W   = (CNT_W > 11) ? CNT_W : 11;
  localparam int MP_W   = 15 + MB_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_DIV_LO = 3'd2;
  localparam logic [2:0] ST_DIV_HI = 3'd3;
  localparam logic [2:0] ST_SCAN   = 3'd4;
  localparam logic [2:0] ST_SCALE  = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  logic [2:0]        state_r;

  // configuration
  logic [11:0]       plot_r;
  logic [11:0]       height_r;

  // store fill
  logic [CNT_W-1:0]  count_r;

  // query working registers
  logic [11:0]       col_r;
  logic [MP_W-1:0]   prod_r;
  logic [11:0]       rem_r;
  logic [DIV_W-1:0]  quo_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  from_r;
  logic [CNT_W-1:0]  to_r;
  logic [CNT_W-1:0]  idx_r;
  logic              rd_vld_r;
  logic signed [15:0] peak_r;

  // pending result
  logic              res_bar_r;
  logic [10:0]       res_reach_r;
  logic              res_full_r;

  // output register
  logic              out_valid_r;
  logic              out_bar_r;
  logic [10:0]       out_reach_r;
  logic              out_full_r;

  logic              in_xfer;
  logic              slot_free;

  // ram ports
  logic              ram_wr_en;
  logic              ram_rd_en;
  logic [15:0]       ram_rd_data;

  // shared multiplier
  logic [14:0]       mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [MP_W-1:0]   mul_p;

  // shared divider step, divisor is plot_columns
  logic [12:0]       trial;
  logic              ge;
  logic [12:0]       diff;
  logic [11:0]       rem_nxt;
  logic [DIV_W-1:0]  quo_nxt;
  logic              div_last;

  // scan and scaling
  logic              issue;
  logic [14:0]       peak_clamp;
  logic [10:0]       half;
  logic [10:0]       scaled;
  logic              no_bar;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  assign ram_wr_en = in_xfer && (in_req_type == REQ_APPEND) &&
                     (count_r < CNT_W'(MAX_SAMPLES));

  // span scan issues one read a cycle from idx up to the span end
  assign issue     = (state_r == ST_SCAN) && (idx_r != to_r);
  assign ram_rd_en = issue;

  wcpb_ram #(
    .WIDTH (16),
    .DEPTH (MAX_SAMPLES),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(count_r[ADDR_W-1:0]),
    .wr_data(in_sample),
    .rd_en  (ram_rd_en),
    .rd_addr(idx_r[ADDR_W-1:0]),
    .rd_data(ram_rd_data)
  );

  // query setup: col * count; scaling: clamped peak * (height/2 - 1)
  assign peak_clamp = (peak_r > Q_ONE) ? Q_ONE[14:0] : peak_r[14:0];
  assign half       = height_r[11:1] - 11'd1;

  always_comb begin
    if (state_r == ST_SCALE) begin
      mul_a = peak_clamp;
      mul_b = MB_W'(half);
    end else begin
      mul_a = {3'b000, col_r};
      mul_b = MB_W'(count_r);
    end
  end

  assign mul_p  = MP_W'(mul_a) * MP_W'(mul_b);
  assign scaled = prod_r[Q_FRAC +: 11];

  // restoring division, one quotient bit a cycle
  assign trial    = {rem_r, quo_r[DIV_W-1]};
  assign ge       = (trial >= {1'b0, plot_r});
  assign diff     = trial - {1'b0, plot_r};
  assign rem_nxt  = ge ? diff[11:0] : trial[11:0];
  assign quo_nxt  = {quo_r[DIV_W-2:0], ge};
  assign div_last = (step_r == STEP_W'(DIV_W - 1));

  // store empty, column off the plot (covers zero columns) or strip too short
  assign no_bar = (count_r == '0) || (in_column >= plot_r) || (height_r < MIN_HEIGHT);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plot_r   <= PLOT_COLUMNS_RST;
      height_r <= STRIP_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PLOT_COLUMNS: plot_r   <= cfg_wdata;
        CFG_STRIP_HEIGHT: height_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // sequencer and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            case (in_req_type)
              REQ_CLEAR: begin
                count_r <= '0;
                state_r <= ST_DONE;
              end
              REQ_APPEND: begin
                if (count_r < CNT_W'(MAX_SAMPLES)) begin
                  count_r <= count_r + 1'b1;
                end
                state_r <= ST_DONE;
              end
              REQ_QUERY: begin
                state_r <= no_bar ? ST_DONE : ST_MUL;
              end
              default: begin
                state_r <= ST_DONE;
              end
            endcase
          end
        end
        ST_MUL: begin
          state_r <= ST_DIV_LO;
        end
        ST_DIV_LO: begin
          if (div_last) begin
            state_r <= ST_DIV_HI;
          end
        end
        ST_DIV_HI: begin
          if (div_last) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_vld_r <= issue;
          if (!issue && !rd_vld_r) begin
            state_r <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          // a peak at or below zero draws nothing
          state_r <= (peak_r > 16'sd0) ? ST_FIN : ST_DONE;
        end
        ST_FIN: begin
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (slot_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        col_r       <= in_column;
        res_bar_r   <= 1'b0;
        res_reach_r <= '0;
        res_full_r  <= (in_req_type == REQ_APPEND) && (count_r == CNT_W'(MAX_SAMPLES));
      end
      ST_MUL: begin
        // keep the product for the span end, start the span start division
        prod_r <= mul_p;
        quo_r  <= mul_p[DIV_W-1:0];
        rem_r  <= '0;
        step_r <= '0;
      end
      ST_DIV_LO: begin
        if (div_last) begin
          from_r <= quo_nxt[CNT_W-1:0];
          quo_r  <= prod_r[DIV_W-1:0] + DIV_W'(count_r);
          rem_r  <= '0;
          step_r <= '0;
        end else begin
          quo_r  <= quo_nxt;
          rem_r  <= rem_nxt;
          step_r <= step_r + 1'b1;
        end
      end
      ST_DIV_HI: begin
        if (div_last) begin
          // span holds at least one sample
          to_r   <= (quo_nxt[CNT_W-1:0] <= from_r) ? from_r + 1'b1 : quo_nxt[CNT_W-1:0];
          idx_r  <= from_r;
          peak_r <= '0;
        end else begin
          quo_r  <= quo_nxt;
          rem_r  <= rem_nxt;
          step_r <= step_r + 1'b1;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          idx_r <= idx_r + 1'b1;
        end
        if (rd_vld_r && ($signed(ram_rd_data) > peak_r)) begin
          peak_r <= $signed(ram_rd_data);
        end
      end
      ST_SCALE: begin
        prod_r <= mul_p;
      end
      ST_FIN: begin
        res_bar_r   <= 1'b1;
        res_reach_r <= (scaled == '0) ? 11'd1 : scaled;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && slot_free) begin
      out_bar_r   <= res_bar_r;
      out_reach_r <= res_reach_r;
      out_full_r  <= res_full_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bar_present = out_bar_r;
  assign out_reach       = out_reach_r;
  assign out_store_full  = out_full_r;

  // the fill count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond store depth");

  // the scanned span is never empty and stays inside the filled store
  a_span_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (to_r > from_r) && (to_r <= count_r) && (idx_r <= to_r))
    else $error("scan span out of range");

  // a new result is only loaded from the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result appeared outside done state");

  // a bar always has a nonzero half-height
  a_bar_reach: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bar_r |-> (out_reach_r != '0) && !out_full_r)
    else $error("bar result with zero reach");

endmodule

`default_nettype wire

// ===== bench/waveform_column_peak_bars_tb.sv =====
// ----------------------------------------------------------------------------
// waveform_column_peak_bars_tb: self-checking bench for the column peak bars
// a queue-fed driver sends clear, append, query and unknown requests with
// random gaps; a monitor stalls at random and checks every result against a
// bench-side model of the sample store, the registers and the bar arithmetic
// ----------------------------------------------------------------------------

module waveform_column_peak_bars_tb;
  import wcpb_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 5;
  localparam int MAX_GAP         = 16;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 64;
  localparam int PRINT_CAP       = 100;
  // worst case: every item a full-store scan plus both sides idling, times three
  localparam longint TIMEOUT_TIME = 64'd80_000_000;

  // request code the block answers with an empty result
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  // register indexes with no register behind them
  localparam logic [1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [1:0] CFG_SPARE_3 = 2'd3;

  localparam logic signed [15:0] LEVEL_MIN = 16'sh8000;
  localparam logic signed [15:0] LEVEL_MAX = 16'sh7fff;

  typedef struct packed {
    logic [1:0]         req;
    logic signed [15:0] level;
    logic [11:0]        column;
  } bar_req_t;

  typedef struct packed {
    logic        bar;
    logic [10:0] reach;
    logic        full;
  } bar_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_req_type = REQ_CLEAR;
  logic signed [15:0] in_sample = '0;
  logic [11:0]        in_column = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_bar_present;
  logic [10:0]        out_reach;
  logic               out_store_full;

  logic               cfg_wr_en = 1'b0;
  logic [1:0]         cfg_index = CFG_PLOT_COLUMNS;
  logic [11:0]        cfg_wdata = '0;

  waveform_column_peak_bars i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_sample       (in_sample),
    .in_column       (in_column),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_bar_present (out_bar_present),
    .out_reach       (out_reach),
    .out_store_full  (out_store_full),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // bench copy of the block state
  logic signed [15:0] stored_level [WCPB_MAX_SAMPLES];
  int stored_count;
  int mirror_plot;
  int mirror_height;

  // requests waiting for the driver, bars waiting for the monitor
  bar_req_t    requests_to_send[$];
  bar_result_t bars_due[$];

  // bookkeeping
  int mismatches;
  int transfers_in;
  int results_seen;
  int bars_drawn;
  int appends_dropped;
  int reg_writes;
  int settings_run;
  int deepest_fill;

  // idling state of both sides
  bit snd_busy = 1'b1;
  bit rcv_busy = 1'b1;
  int gap_left;
  int stall_left;
  bit take_next;
  bar_req_t next_req;

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    // quiet after the first hundred, still counted
    if (mismatches <= PRINT_CAP)
      $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
  endtask

  // half-height of one column, zero when the column draws nothing
  function automatic logic [10:0] peak_reach(input logic [11:0] col);
    longint lo;
    longint hi;
    longint idx;
    int     peak;
    int     r;
    if (stored_count == 0 || mirror_plot == 0 || int'(col) >= mirror_plot ||
        mirror_height < int'(MIN_HEIGHT))
      return '0;
    lo = longint'(col) * stored_count / mirror_plot;
    hi = (longint'(col) + 1) * stored_count / mirror_plot;
    // a column always covers at least one sample
    if (hi <= lo)
      hi = lo + 1;
    peak = 0;
    for (idx = lo; idx < hi && idx < stored_count; idx++) begin
      if (int'(stored_level[idx]) > peak)
        peak = int'(stored_level[idx]);
    end
    if (peak <= 0)
      return '0;
    // clamp to full scale
    if (peak > int'(Q_ONE))
      peak = int'(Q_ONE);
    r = peak * (mirror_height / 2 - 1) / int'(Q_ONE);
    // a positive peak never vanishes
    if (r < 1)
      r = 1;
    return r[10:0];
  endfunction

  // advance the bench state by one accepted request, queue its result
  task automatic apply_request(input bar_req_t item);
    bar_result_t res;
    logic [10:0] reach;
    res = '0;
    case (item.req)
      REQ_CLEAR: begin
        stored_count = 0;
      end
      REQ_APPEND: begin
        if (stored_count < WCPB_MAX_SAMPLES) begin
          stored_level[stored_count] = item.level;
          stored_count++;
          if (stored_count > deepest_fill)
            deepest_fill = stored_count;
        end else begin
          res.full = 1'b1;
        end
      end
      REQ_QUERY: begin
        reach = peak_reach(item.column);
        if (reach != 0) begin
          res.bar = 1'b1;
          res.reach = reach;
        end
      end
      default: begin
      end
    endcase
    bars_due.push_back(res);
  endtask

  // driver: holds a payload until its transfer, then idles a drawn number of cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      take_next = 1'b0;
      if (in_valid && !in_stall) begin
        apply_request('{req: in_req_type, level: in_sample, column: in_column});
        transfers_in++;
        if ($urandom_range(0, 39) == 0)
          snd_busy = !snd_busy;
        gap_left = snd_busy ? $urandom_range(0, MAX_GAP) : 0;
        take_next = (gap_left == 0);
      end else if (!in_valid) begin
        if (gap_left > 0)
          gap_left--;
        take_next = (gap_left == 0);
      end
      if (take_next && requests_to_send.size() > 0) begin
        next_req = requests_to_send.pop_front();
        in_valid    <= 1'b1;
        in_req_type <= next_req.req;
        in_sample   <= next_req.level;
        in_column   <= next_req.column;
      end else if (in_valid && !in_stall) begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks each transfer out, then stalls a drawn number of cycles
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (bars_due.size() == 0) begin
          flag_mismatch("result with nothing due, bar", out_bar_present, 0);
        end else begin
          bar_result_t want;
          want = bars_due.pop_front();
          if (out_bar_present !== want.bar)
            flag_mismatch("bar_present", out_bar_present, want.bar);
          if (out_reach !== want.reach)
            flag_mismatch("reach", out_reach, want.reach);
          if (out_store_full !== want.full)
            flag_mismatch("store_full", out_store_full, want.full);
          if (want.bar)
            bars_drawn++;
          if (want.full)
            appends_dropped++;
        end
        if ($urandom_range(0, 39) == 0)
          rcv_busy = !rcv_busy;
        // long hold-off while the driver keeps offering, so the block backs up
        if (results_seen == 400 || results_seen == 1500)
          stall_left = HOLD_OFF_CYCLES;
        else
          stall_left = rcv_busy ? $urandom_range(0, MAX_GAP) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  task automatic push_req(input logic [1:0] req, input logic signed [15:0] level,
                          input logic [11:0] column);
    requests_to_send.push_back('{req: req, level: level, column: column});
  endtask

  // levels biased toward full scale, the clamp and the sign
  function automatic logic signed [15:0] random_level();
    case ($urandom_range(0, 7))
      0: return Q_ONE;
      1: return LEVEL_MAX;
      2: return LEVEL_MIN;
      3: return 16'($urandom_range(0, 16384));
      4: return 16'($urandom_range(1, 64));
      5: return 16'($urandom_range(15000, 20000));
      6: return -16'($urandom_range(1, 32767));
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly columns inside the plot, some anywhere
  function automatic logic [11:0] random_column();
    if (mirror_plot > 0 && $urandom_range(0, 4) != 0)
      return 12'($urandom_range(0, mirror_plot - 1));
    return 12'($urandom_range(0, 4095));
  endfunction

  // framed fill-then-read sequences mixed with loose single requests
  task automatic add_traffic(input int n_items);
    int done_items;
    int fill;
    int reads;
    int k;
    int pick;
    done_items = 0;
    while (done_items < n_items) begin
      if ($urandom_range(0, 5) == 0) begin
        fill = $urandom_range(1, 48);
        reads = $urandom_range(1, 12);
        push_req(REQ_CLEAR, random_level(), random_column());
        for (k = 0; k < fill; k++)
          push_req(REQ_APPEND, random_level(), random_column());
        for (k = 0; k < reads; k++)
          push_req(REQ_QUERY, random_level(), random_column());
        done_items += 1 + fill + reads;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          push_req(REQ_CLEAR, random_level(), random_column());
          done_items++;
        end else if (pick < 8) begin
          // answered by the block with an empty result, not counted
          push_req(REQ_UNKNOWN, 16'($urandom), 12'($urandom));
        end else if (pick < 50) begin
          push_req(REQ_APPEND, random_level(), random_column());
          done_items++;
        end else begin
          push_req(REQ_QUERY, random_level(), random_column());
          done_items++;
        end
      end
    end
  endtask

  // wait for every transfer and every result, then a few quiet cycles;
  // sampled mid-cycle so the driver's updates at the edge are already in
  task automatic settle();
    while (!(requests_to_send.size() == 0 && !in_valid && bars_due.size() == 0))
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_PLOT_COLUMNS: mirror_plot = int'(value);
      CFG_STRIP_HEIGHT: mirror_height = int'(value);
      default: begin
      end
    endcase
  endtask

  // run timeout
  initial begin
    #TIMEOUT_TIME;
    $display("FAIL waveform_column_peak_bars");
    $finish;
  end

  initial begin
    int k;
    int phase;
    logic [11:0] plot_pick [7];
    logic [11:0] height_pick [7];

    stored_count = 0;
    mirror_plot = int'(PLOT_COLUMNS_RST);
    mirror_height = int'(STRIP_HEIGHT_RST);
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    settings_run = 1;

    // directed: reset registers, empty store, then a handful of hand-picked levels
    push_req(REQ_QUERY, '0, 12'd0);
    push_req(REQ_APPEND, Q_ONE, 12'd0);
    push_req(REQ_APPEND, LEVEL_MAX, 12'd0);
    push_req(REQ_APPEND, LEVEL_MIN, 12'hfff);
    push_req(REQ_APPEND, 16'sd0, 12'd0);
    push_req(REQ_APPEND, 16'sd1, 12'd0);
    push_req(REQ_APPEND, Q_ONE - 16'sd1, 12'd0);
    push_req(REQ_APPEND, -16'sd1, 12'd0);
    // one column per stored level: full scale, clamped, negative, zero,
    // tiny positive rounded up, just under full scale, last column negative
    push_req(REQ_QUERY, LEVEL_MIN, 12'd0);
    push_req(REQ_QUERY, '0, 12'd40);
    push_req(REQ_QUERY, '0, 12'd80);
    push_req(REQ_QUERY, '0, 12'd120);
    push_req(REQ_QUERY, '0, 12'd150);
    push_req(REQ_QUERY, '0, 12'd200);
    push_req(REQ_QUERY, '0, 12'd255);
    // columns past the plot
    push_req(REQ_QUERY, '0, 12'd256);
    push_req(REQ_QUERY, LEVEL_MAX, 12'hfff);
    push_req(REQ_UNKNOWN, LEVEL_MAX, 12'hfff);
    push_req(REQ_CLEAR, LEVEL_MAX, 12'hfff);
    push_req(REQ_QUERY, '0, 12'd0);
    push_req(REQ_APPEND, LEVEL_MIN, 12'd0);
    push_req(REQ_QUERY, '0, 12'd0);
    settle();

    // widest plot and tallest strip while the store fills past its end
    write_reg(CFG_PLOT_COLUMNS, 12'd4095);
    write_reg(CFG_STRIP_HEIGHT, 12'd4095);
    settings_run++;
    push_req(REQ_CLEAR, '0, '0);
    for (k = 0; k < WCPB_MAX_SAMPLES + 6; k++) begin
      push_req(REQ_APPEND, random_level(), random_column());
      if ($urandom_range(0, 19) == 0)
        push_req(REQ_QUERY, random_level(), random_column());
    end
    push_req(REQ_QUERY, '0, 12'd4094);
    push_req(REQ_QUERY, '0, 12'd0);
    settle();

    // one column over the whole full store, then three wide columns
    write_reg(CFG_PLOT_COLUMNS, 12'd1);
    settings_run++;
    push_req(REQ_QUERY, '0, 12'd0);
    push_req(REQ_QUERY, '0, 12'd1);
    settle();
    write_reg(CFG_PLOT_COLUMNS, 12'd3);
    settings_run++;
    for (k = 0; k < 3; k++)
      push_req(REQ_QUERY, '0, 12'(k));
    settle();

    // register settings for the random phases: smallest plot and strip, empty
    // plot, short strip, extremes mixed, two random, back to reset values
    plot_pick   = '{12'd1, 12'd0, 12'd13, 12'd4095, 12'd0, 12'd0, PLOT_COLUMNS_RST};
    height_pick = '{MIN_HEIGHT, 12'd64, 12'd5, 12'd7, 12'd0, 12'd0, STRIP_HEIGHT_RST};
    plot_pick[4]   = 12'($urandom_range(2, 300));
    height_pick[4] = 12'($urandom_range(6, 4095));
    plot_pick[5]   = 12'($urandom_range(1, 4095));
    height_pick[5] = 12'($urandom_range(0, 4095));
    for (phase = 0; phase < 7; phase++) begin
      write_reg(CFG_PLOT_COLUMNS, plot_pick[phase]);
      write_reg(CFG_STRIP_HEIGHT, height_pick[phase]);
      // writes to unused indexes must leave both registers alone
      if (phase == 2) begin
        write_reg(CFG_SPARE_2, 12'hfff);
        write_reg(CFG_SPARE_3, 12'($urandom));
      end
      settings_run++;
      add_traffic(110);
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bars_due.size() != 0)
      flag_mismatch("results never delivered", 0, bars_due.size());
    $display("run: %0d transfers in, %0d results, %0d bars drawn, %0d appends dropped",
             transfers_in, results_seen, bars_drawn, appends_dropped);
    $display("run: %0d register writes over %0d settings, store filled to %0d samples",
             reg_writes, settings_run, deepest_fill);
    if (mismatches == 0) begin
      $display("PASS waveform_column_peak_bars");
    end else begin
      $display("FAIL waveform_column_peak_bars");
    end
    $finish;
  end

endmodule
